// ===== hw/rtl/vibrato_modulated_delay_defines.svh =====
// Assertion macros shared by the vibrato RTL
`ifndef VIBRATO_MODULATED_DELAY_DEFINES_SVH
`define VIBRATO_MODULATED_DELAY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vmd_pkg.sv =====
// Package: register map, fixed widths, constants and shared types of the vibrato
`timescale 1ns / 1ps

package vmd_pkg;

    localparam int CFG_ADDR_BITS = 5;

    localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [2:0] REG_PHASE_PERIOD = 3'd1;
    localparam logic [2:0] REG_MAX_DELAY    = 3'd2;
    localparam logic [2:0] REG_LINE_LENGTH  = 3'd3;
    localparam logic [2:0] REG_DEPTH_GAIN   = 3'd4;

    localparam int STEP_BITS   = 32;
    localparam int PERIOD_BITS = 20;
    localparam int MAXD_BITS   = 10;
    localparam int LEN_CFG_BITS = 11;
    localparam int DEPTH_BITS  = 17;

    localparam logic [31:0] RST_PHASE_STEP   = 32'd194783;
    localparam logic [19:0] RST_PHASE_PERIOD = 20'd22050;
    localparam logic [9:0]  RST_MAX_DELAY    = 10'd88;
    localparam logic [10:0] RST_LINE_LENGTH  = 11'd176;
    localparam logic [16:0] RST_DEPTH_GAIN   = 17'd32768;
    localparam logic [16:0] FULL_DEPTH       = 17'd65536;

    // quarter-wave sine polynomial
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;

    // whole-sample offset of the read point, Q16
    localparam logic [27:0] EXTRA_DELAY_Q16 = 28'd196608;

    // whole part of the delay plus two fits in this many bits
    localparam int NUM_BITS = 12;

    typedef struct packed {
        logic rd;
        logic wr;
    } line_ctl_t;

endpackage

// ===== hw/rtl/vmd_delay_line.sv =====
// Delay line memory with a clearing sweep after reset
`timescale 1ns / 1ps

`include "vibrato_modulated_delay_defines.svh"

module vmd_delay_line #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  vmd_pkg::line_ctl_t       ctl,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data,
    output logic                     clearing
);
    import vmd_pkg::*;

    localparam int AB = $clog2(DEPTH);
    localparam logic [AB-1:0] LAST = AB'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AB-1:0]    clr_addr_reg;
    logic             clr_busy_reg;
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

    `VMD_ASSERT_NOW(a_no_access_in_clear, clr_busy_reg, !ctl.rd && !ctl.wr,
        "delay line accessed during clearing sweep")
    `VMD_ASSERT_NEXT(a_clear_ends_at_last, clr_busy_reg && clr_addr_reg == LAST,
        !clr_busy_reg, "clearing sweep did not end at last entry")
    `VMD_ASSERT_NOW(a_no_rd_wr_same, ctl.rd && ctl.wr, 1'b0,
        "read and write issued in one cycle")

endmodule

// ===== hw/rtl/vibrato_modulated_delay.sv =====
// Vibrato: sine LFO sweeps the read point of a delay line, Hermite-interpolated.
// Sequence after accept: sine states, delay states, a 12-step remainder when the
// read point wraps behind the line start, tap reads, Hermite states, output beat;
// shared 39x18 multiplier. The next sample is accepted in the cycle after the output
// beat is taken. After reset a clearing sweep zeroes the line; no sample is accepted
// meanwhile. Registers reset to their defaults, LFO and pointer to 0.
`timescale 1ns / 1ps

`include "vibrato_modulated_delay_defines.svh"

module vibrato_modulated_delay #(
    parameter int LINE_DEPTH     = 1024,
    parameter int SAMPLE_BITS    = 24,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vmd_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);
    import vmd_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int AB  = $clog2(LINE_DEPTH);
    localparam int LW  = AB + 1;
    localparam int AW  = (SB + 15 > 35) ? SB + 15 : 35;
    localparam int PW  = AW + 18;
    localparam int CW  = SB + 4;
    localparam int SCB = $clog2(NUM_BITS);
    localparam logic [31:0] AMASK = ~((32'd1 << (32 - SINE_ADDR_BITS)) - 32'd1);
    localparam logic [LW-1:0] LEN_MAX = LW'(LINE_DEPTH);
    localparam logic signed [PW-1:0] LIM_HI = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] LIM_LO = -LIM_HI - PW'(1);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_SIN0 = 15'b000000000000010,
        S_SIN1 = 15'b000000000000100,
        S_SIN2 = 15'b000000000001000,
        S_SIN3 = 15'b000000000010000,
        S_SIN4 = 15'b000000000100000,
        S_DLY0 = 15'b000000001000000,
        S_DLY1 = 15'b000000010000000,
        S_MOD  = 15'b000000100000000,
        S_TAP  = 15'b000001000000000,
        S_H0   = 15'b000010000000000,
        S_H1   = 15'b000100000000000,
        S_H2   = 15'b001000000000000,
        S_H3   = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } state_t;

    // configuration
    logic [31:0] phase_step_reg;
    logic [19:0] phase_period_reg;
    logic [9:0]  max_delay_reg;
    logic [10:0] line_length_reg;
    logic [16:0] depth_gain_reg;

    state_t state_reg, state_next;

    logic [19:0]       lfo_phase_reg;
    logic [31:0]       lfo_angle_reg;
    logic [AB-1:0]     wp_reg;
    logic [LW-1:0]     len_reg;
    logic [16:0]       depth_reg;
    logic signed [SB-1:0] sample_reg;
    logic [15:0]       t_reg;
    logic [1:0]        quad_reg;
    logic [15:0]       t2_reg;
    logic signed [PW-1:0] mul_reg;
    logic [15:0]       frac_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [LW:0]       rem_reg;
    logic [SCB-1:0]    step_reg;
    logic [AB-1:0]     addr_reg;
    logic [2:0]        tap_cnt_reg;
    logic signed [SB-1:0] tap_reg [4];
    logic signed [SB-1:0] out_reg;

    logic signed [AW-1:0] mul_a;
    logic signed [17:0]   mul_b;

    line_ctl_t      line_ctl;
    logic [SB-1:0]  line_rd_data;
    logic           clearing;

    logic cfg_wr;
    logic in_acc;

    // accept-time values
    logic [LW-1:0] len_acc;
    logic [AB-1:0] wp_acc;
    logic [31:0]   q_acc;
    logic [14:0]   r_acc;
    logic [20:0]   phase_inc;

    // sine and delay intermediates
    logic [15:0]   t2_w;
    logic [14:0]   inner_w;
    logic [15:0]   mid_w;
    logic [16:0]   y_w;
    logic [15:0]   ycap_w;
    logic [15:0]   lfo_u_w;
    logic [27:0]   delay_w;
    logic [15:0]   f_w;
    logic signed [NUM_BITS+1:0] n_w;

    // remainder step
    logic [LW:0]   rem_shift;
    logic [LW:0]   rem_step;
    logic [AB-1:0] addr_inc;

    // Hermite
    logic signed [CW-1:0] y0, y1, y2, y3, c0, c1, c2, c3;
    logic signed [PW-1:0] h_sum0, h_sum1, h_sum2;
    logic signed [AW-1:0] h_t1, h_t2;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= RST_PHASE_STEP;
            phase_period_reg <= RST_PHASE_PERIOD;
            max_delay_reg    <= RST_MAX_DELAY;
            line_length_reg  <= RST_LINE_LENGTH;
            depth_gain_reg   <= RST_DEPTH_GAIN;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_PHASE_STEP:   phase_step_reg   <= pwdata;
                REG_PHASE_PERIOD: phase_period_reg <= pwdata[19:0];
                REG_MAX_DELAY:    max_delay_reg    <= pwdata[9:0];
                REG_LINE_LENGTH:  line_length_reg  <= pwdata[10:0];
                REG_DEPTH_GAIN:   depth_gain_reg   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_PHASE_STEP:   prdata = phase_step_reg;
            REG_PHASE_PERIOD: prdata = {12'd0, phase_period_reg};
            REG_MAX_DELAY:    prdata = {22'd0, max_delay_reg};
            REG_LINE_LENGTH:  prdata = {21'd0, line_length_reg};
            REG_DEPTH_GAIN:   prdata = {15'd0, depth_gain_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign in_stall  = !(state_reg == S_IDLE) || clearing;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign sample_out = out_reg;

    // accept-time clamps
    always_comb
    begin
        if (line_length_reg < 11'd4)
        begin
            len_acc = LW'(4);
        end
        else if (32'(line_length_reg) > 32'(LINE_DEPTH))
        begin
            len_acc = LEN_MAX;
        end
        else
        begin
            len_acc = LW'(line_length_reg);
        end
        wp_acc    = (LW'(wp_reg) >= len_acc) ? '0 : wp_reg;
        q_acc     = lfo_angle_reg & AMASK;
        r_acc     = q_acc[29:15];
        phase_inc = 21'(lfo_phase_reg) + 21'd1;
    end

    // sine chain and delay
    always_comb
    begin
        t2_w    = mul_reg[30:15];
        inner_w = 15'(SIN_B - 16'(mul_reg[PW-1:15]));
        mid_w   = SIN_A - 16'(mul_reg[PW-1:15]);
        y_w     = mul_reg[31:15];
        ycap_w  = (y_w > 17'd32767) ? 16'd32767 : y_w[15:0];
        lfo_u_w = quad_reg[1] ? 16'(17'd32768 - 17'(ycap_w))
                              : 16'(17'd32768 + 17'(ycap_w));
        delay_w = 28'(mul_reg[PW-1:15]) + EXTRA_DELAY_Q16;
        f_w     = delay_w[15:0];
        n_w     = $signed({2'b00, delay_w[27:16]})
                + ((f_w != 16'd0) ? (NUM_BITS+2)'(2) : (NUM_BITS+2)'(1))
                - $signed((NUM_BITS+2)'(wp_reg));
    end

    always_comb
    begin
        rem_shift = {rem_reg[LW-1:0], num_reg[NUM_BITS-1]};
        rem_step  = (rem_shift >= (LW+1)'(len_reg)) ? rem_shift - (LW+1)'(len_reg)
                                                   : rem_shift;
        addr_inc  = (LW'(addr_reg) + LW'(1) >= len_reg) ? '0 : addr_reg + 1'b1;
    end

    always_comb
    begin
        y0 = CW'(tap_reg[0]);
        y1 = CW'(tap_reg[1]);
        y2 = CW'(tap_reg[2]);
        y3 = CW'(tap_reg[3]);
        c0 = y1 <<< 1;
        c1 = y2 - y0;
        c2 = (y0 <<< 1) - (y1 <<< 2) - y1 + (y2 <<< 2) - y3;
        c3 = (y3 - y0) + (((y1 - y2) <<< 1) + (y1 - y2));
        h_sum0 = mul_reg + (PW'(c2) <<< 16);
        h_t1   = AW'(h_sum0 >>> 8);
        h_sum1 = mul_reg + (PW'(c1) <<< 24);
        h_t2   = AW'(h_sum1 >>> 16);
        h_sum2 = (mul_reg + (PW'(c0) <<< 24) + (PW'(1) <<< 24)) >>> 25;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SIN0:
            begin
                mul_a = AW'(t_reg);
                mul_b = 18'(t_reg);
            end
            S_SIN1:
            begin
                mul_a = AW'(SIN_C);
                mul_b = 18'(t2_w);
            end
            S_SIN2:
            begin
                mul_a = AW'(t2_reg);
                mul_b = 18'(inner_w);
            end
            S_SIN3:
            begin
                mul_a = AW'(t_reg);
                mul_b = 18'(mid_w);
            end
            S_SIN4:
            begin
                mul_a = AW'(lfo_u_w);
                mul_b = 18'(depth_reg);
            end
            S_DLY0:
            begin
                mul_a = AW'(mul_reg[32:0]);
                mul_b = 18'(max_delay_reg);
            end
            S_H0:
            begin
                mul_a = AW'(c3);
                mul_b = 18'(frac_reg);
            end
            S_H1:
            begin
                mul_a = h_t1;
                mul_b = 18'(frac_reg);
            end
            S_H2:
            begin
                mul_a = h_t2;
                mul_b = 18'(frac_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc) state_next = S_SIN0;
            S_SIN0: state_next = S_SIN1;
            S_SIN1: state_next = S_SIN2;
            S_SIN2: state_next = S_SIN3;
            S_SIN3: state_next = S_SIN4;
            S_SIN4: state_next = S_DLY0;
            S_DLY0: state_next = S_DLY1;
            S_DLY1: state_next = (n_w > 0) ? S_MOD : S_TAP;
            S_MOD:  if (step_reg == SCB'(NUM_BITS - 1)) state_next = S_TAP;
            S_TAP:  if (tap_cnt_reg == 3'd4) state_next = S_H0;
            S_H0:   state_next = S_H1;
            S_H1:   state_next = S_H2;
            S_H2:   state_next = S_H3;
            S_H3:   state_next = S_OUT;
            S_OUT:  if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        line_ctl.rd = (state_reg == S_TAP) && (tap_cnt_reg != 3'd4);
        line_ctl.wr = (state_reg == S_TAP) && (tap_cnt_reg == 3'd4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lfo_phase_reg <= '0;
            lfo_angle_reg <= '0;
            wp_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                wp_reg <= wp_acc;
                if (phase_inc >= 21'(phase_period_reg))
                begin
                    lfo_phase_reg <= '0;
                    lfo_angle_reg <= '0;
                end
                else
                begin
                    lfo_phase_reg <= phase_inc[19:0];
                    lfo_angle_reg <= lfo_angle_reg + phase_step_reg;
                end
            end
            else if (state_reg == S_H3)
            begin
                wp_reg <= (LW'(wp_reg) + LW'(1) >= len_reg) ? '0 : wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                sample_reg <= sample_in;
                len_reg    <= len_acc;
                depth_reg  <= (depth_gain_reg > FULL_DEPTH) ? FULL_DEPTH : depth_gain_reg;
                quad_reg   <= q_acc[31:30];
                t_reg      <= q_acc[30] ? 16'(17'd32768 - 17'(r_acc)) : 16'(r_acc);
            end
            S_SIN1: t2_reg <= t2_w;
            S_DLY1:
            begin
                // frac = 1 - fractional delay when the delay is not whole
                frac_reg    <= 16'(17'h10000 - 17'(f_w));
                num_reg     <= NUM_BITS'(n_w);
                rem_reg     <= '0;
                step_reg    <= '0;
                tap_cnt_reg <= '0;
                addr_reg    <= AB'(-n_w);
            end
            S_MOD:
            begin
                rem_reg  <= rem_step;
                num_reg  <= num_reg << 1;
                step_reg <= step_reg + 1'b1;
                if (step_reg == SCB'(NUM_BITS - 1))
                begin
                    addr_reg <= AB'(((rem_step == '0) ? LW'(0)
                                     : len_reg - rem_step[LW-1:0]));
                end
            end
            S_TAP:
            begin
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
                addr_reg    <= addr_inc;
                if (tap_cnt_reg != 3'd0)
                begin
                    tap_reg[2'(tap_cnt_reg - 3'd1)] <= line_rd_data;
                end
            end
            S_H3:
            begin
                if (h_sum2 > LIM_HI)
                begin
                    out_reg <= LIM_HI[SB-1:0];
                end
                else if (h_sum2 < LIM_LO)
                begin
                    out_reg <= LIM_LO[SB-1:0];
                end
                else
                begin
                    out_reg <= h_sum2[SB-1:0];
                end
            end
            default: ;
        endcase
    end

    vmd_delay_line #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (SB)
    ) u_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (line_ctl),
        .rd_addr  (addr_reg),
        .wr_addr  (wp_reg),
        .wr_data  (sample_reg),
        .rd_data  (line_rd_data),
        .clearing (clearing)
    );

    `VMD_ASSERT_NEXT(a_accept_starts, in_acc, state_reg == S_SIN0,
        "accepted beat did not start the sequencer")
    `VMD_ASSERT_NOW(a_tap_in_line, state_reg == S_TAP, LW'(addr_reg) < len_reg,
        "tap address beyond line in use")
    `VMD_ASSERT_NOW(a_wp_in_line, state_reg == S_TAP, LW'(wp_reg) < len_reg,
        "write pointer beyond line in use")
    `VMD_ASSERT_NEXT(a_out_holds, out_valid && out_stall,
        out_valid && $stable(sample_out), "stalled output beat changed")

endmodule
